// ===== src/ms_pkg.sv =====
package ms_pkg;

    // Default run capacity and element width
    localparam int CAPACITY = 64;
    localparam int VALUE_W  = 32;

    // Request on the input channel
    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic                      last;
    } in_item_t;

    // Request on the result channel
    typedef struct packed {
        logic signed [VALUE_W-1:0] sorted_value;
        logic                      last_out;
        logic                      overflow;
    } out_item_t;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_LOAD,
        ST_SORT_START,
        ST_SPAN_INIT,
        ST_RD_LEFT,
        ST_RD_RIGHT,
        ST_RD_CAP,
        ST_MERGE,
        ST_MERGE_CAP,
        ST_OUT_RD,
        ST_OUT_WR
    } state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic load_en;
        logic span_init;
        logic rd_left;
        logic rd_right;
        logic rd_cap;
        logic merge;
        logic merge_cap;
        logic span_next;
        logic pass_next;
        logic out_init;
        logic out_rd;
        logic out_load;
    } cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic in_last;
        logic w_lt_n;
        logic span_done;
        logic span_last;
        logic out_free;
        logic out_last;
    } status_t;

endpackage

// ===== src/merge_sorter.sv =====
// Stable ascending sorter for runs of signed 32-bit values.
// Input channel (s_valid/s_ready/s_data): one value per request, last set
// on the final value of a run. Up to CAPACITY values are kept; further ones
// are dropped and every result of that run then carries overflow.
// Result channel (m_valid/m_ready/m_data): the run in ascending order, one
// value per request, last_out on the final one. Equal values keep arrival order.
// Loading takes one value per cycle while s_valid is high. Each merge pass
// over the two RAM banks reads from one bank and writes the other, and there
// are ceil(log2(n)) passes for a run of n stored values; since the banks have
// a single read port, each merged value takes a merge step and a capture
// step. Output reads each value and then loads it into the output register.
// Inputs are taken only while loading; the next run can start loading while
// the final result still sits in the output register.
// If the receiver stalls, the sorter holds in its output step without losing
// data. Synchronous reset (aresetn low) empties the run and the output
// register; buffer contents are not cleared.
module merge_sorter #(
    parameter int CAPACITY = ms_pkg::CAPACITY
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  ms_pkg::in_item_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output ms_pkg::out_item_t m_data
);

    ms_pkg::cmd_t    cmd;
    ms_pkg::status_t status;

    // Sequencer
    ms_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // Buffers, counters and merge compare
    ms_datapath #(.CAPACITY(CAPACITY)) u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .cmd     (cmd),
        .status  (status)
    );

endmodule

// ===== src/ms_ram.sv =====
module ms_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // One write port, one registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/ms_ctrl.sv =====
module ms_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  ms_pkg::status_t   status,
    output ms_pkg::cmd_t      cmd
);

    ms_pkg::state_t state_reg, state_next;

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ms_pkg::ST_LOAD;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            ms_pkg::ST_LOAD: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load_en = 1'b1;
                    if (status.in_last) begin
                        state_next = ms_pkg::ST_SORT_START;
                    end
                end
            end
            // start of a pass, or straight to output once width covers the run
            ms_pkg::ST_SORT_START: begin
                if (status.w_lt_n) begin
                    state_next = ms_pkg::ST_SPAN_INIT;
                end else begin
                    cmd.out_init = 1'b1;
                    state_next   = ms_pkg::ST_OUT_RD;
                end
            end
            ms_pkg::ST_SPAN_INIT: begin
                cmd.span_init = 1'b1;
                state_next    = ms_pkg::ST_RD_LEFT;
            end
            ms_pkg::ST_RD_LEFT: begin
                cmd.rd_left = 1'b1;
                state_next  = ms_pkg::ST_RD_RIGHT;
            end
            ms_pkg::ST_RD_RIGHT: begin
                cmd.rd_right = 1'b1;
                state_next   = ms_pkg::ST_RD_CAP;
            end
            ms_pkg::ST_RD_CAP: begin
                cmd.rd_cap = 1'b1;
                state_next = ms_pkg::ST_MERGE;
            end
            ms_pkg::ST_MERGE: begin
                cmd.merge  = 1'b1;
                state_next = ms_pkg::ST_MERGE_CAP;
            end
            ms_pkg::ST_MERGE_CAP: begin
                cmd.merge_cap = 1'b1;
                if (!status.span_done) begin
                    state_next = ms_pkg::ST_MERGE;
                end else if (status.span_last) begin
                    cmd.pass_next = 1'b1;
                    state_next    = ms_pkg::ST_SORT_START;
                end else begin
                    cmd.span_next = 1'b1;
                    state_next    = ms_pkg::ST_SPAN_INIT;
                end
            end
            ms_pkg::ST_OUT_RD: begin
                cmd.out_rd = 1'b1;
                state_next = ms_pkg::ST_OUT_WR;
            end
            // hold the read data until the output register frees up
            ms_pkg::ST_OUT_WR: begin
                if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = status.out_last ? ms_pkg::ST_LOAD : ms_pkg::ST_OUT_RD;
                end
            end
            default: begin
                state_next = ms_pkg::ST_LOAD;
            end
        endcase
    end

endmodule

// ===== src/ms_datapath.sv =====
module ms_datapath #(
    parameter int CAPACITY = ms_pkg::CAPACITY
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  ms_pkg::in_item_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output ms_pkg::out_item_t m_data,
    input  ms_pkg::cmd_t      cmd,
    output ms_pkg::status_t   status
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int WW = CW + 1;
    localparam int SW = CW + 2;
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);
    localparam logic [CW-1:0] ONE_C = CW'(1);
    localparam logic [WW-1:0] W_ONE = WW'(1);

    logic [CW-1:0] count_reg, count_next;
    logic          ovf_reg, ovf_next;
    logic          bank_reg, bank_next;
    logic [WW-1:0] w_reg, w_next;
    logic [CW-1:0] lo_reg, lo_next;
    logic [CW-1:0] mid_reg, mid_next;
    logic [CW-1:0] hi_reg, hi_next;
    logic [CW-1:0] i_reg, i_next;
    logic [CW-1:0] j_reg, j_next;
    logic [CW-1:0] k_reg, k_next;
    logic          side_reg, side_next;
    logic signed [ms_pkg::VALUE_W-1:0] head_l_reg, head_l_next;
    logic signed [ms_pkg::VALUE_W-1:0] head_r_reg, head_r_next;
    logic              out_valid_reg, out_valid_next;
    ms_pkg::out_item_t out_data_reg, out_data_next;

    logic [ms_pkg::VALUE_W-1:0] rdata_a, rdata_b, rdata;
    logic                       a_we, b_we, ram_re;
    logic [AW-1:0]              ram_waddr, ram_raddr;
    logic [ms_pkg::VALUE_W-1:0] ram_wdata;

    logic          has_room, left_ok, right_ok, take_left;
    logic [CW-1:0] i_inc, j_inc, k_inc;
    logic [SW-1:0] mid_raw, hi_raw, n_ext;
    logic [CW-1:0] mid_span, hi_span;
    logic signed [ms_pkg::VALUE_W-1:0] chosen;

    // Two banks: passes merge from one into the other
    ms_ram #(.WIDTH(ms_pkg::VALUE_W), .DEPTH(CAPACITY)) u_bank_a (
        .aclk  (aclk),
        .we    (a_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (rdata_a)
    );

    ms_ram #(.WIDTH(ms_pkg::VALUE_W), .DEPTH(CAPACITY)) u_bank_b (
        .aclk  (aclk),
        .we    (b_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (rdata_b)
    );

    assign rdata = bank_reg ? rdata_b : rdata_a;

    // Merge decision; a tie takes the left (earlier) element
    assign has_room  = count_reg < CAP_C;
    assign left_ok   = i_reg < mid_reg;
    assign right_ok  = j_reg < hi_reg;
    assign take_left = left_ok && (!right_ok || (head_l_reg <= head_r_reg));
    assign chosen    = take_left ? head_l_reg : head_r_reg;
    assign i_inc     = i_reg + ONE_C;
    assign j_inc     = j_reg + ONE_C;
    assign k_inc     = k_reg + ONE_C;

    // Span bounds clipped to the run length
    assign n_ext    = SW'(count_reg);
    assign mid_raw  = SW'(lo_reg) + SW'(w_reg);
    assign hi_raw   = SW'(lo_reg) + {w_reg, 1'b0};
    assign mid_span = (mid_raw < n_ext) ? mid_raw[CW-1:0] : count_reg;
    assign hi_span  = (hi_raw < n_ext) ? hi_raw[CW-1:0] : count_reg;

    // Memory ports
    always_comb begin
        ram_re    = cmd.rd_left | cmd.rd_right | cmd.merge | cmd.out_rd;
        ram_raddr = k_reg[AW-1:0];
        if (cmd.rd_left) begin
            ram_raddr = i_reg[AW-1:0];
        end else if (cmd.rd_right) begin
            ram_raddr = j_reg[AW-1:0];
        end else if (cmd.merge) begin
            ram_raddr = take_left ? i_inc[AW-1:0] : j_inc[AW-1:0];
        end
        a_we      = (cmd.load_en && has_room) || (cmd.merge && bank_reg);
        b_we      = cmd.merge && !bank_reg;
        ram_waddr = cmd.load_en ? count_reg[AW-1:0] : k_reg[AW-1:0];
        ram_wdata = cmd.load_en ? s_data.value : chosen;
    end

    // Next-state logic for counters, heads and output register
    always_comb begin
        count_next     = count_reg;
        ovf_next       = ovf_reg;
        bank_next      = bank_reg;
        w_next         = w_reg;
        lo_next        = lo_reg;
        mid_next       = mid_reg;
        hi_next        = hi_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        k_next         = k_reg;
        side_next      = side_reg;
        head_l_next    = head_l_reg;
        head_r_next    = head_r_reg;
        out_data_next  = out_data_reg;
        out_valid_next = m_ready ? 1'b0 : out_valid_reg;

        if (cmd.load_en) begin
            if (has_room) begin
                count_next = count_reg + ONE_C;
            end else begin
                ovf_next = 1'b1;
            end
            if (s_data.last) begin
                w_next  = W_ONE;
                lo_next = '0;
            end
        end
        if (cmd.span_init) begin
            mid_next = mid_span;
            hi_next  = hi_span;
            i_next   = lo_reg;
            j_next   = mid_span;
            k_next   = lo_reg;
        end
        if (cmd.rd_right) begin
            head_l_next = rdata;
        end
        if (cmd.rd_cap) begin
            head_r_next = rdata;
        end
        if (cmd.merge) begin
            k_next    = k_inc;
            side_next = take_left;
            if (take_left) begin
                i_next = i_inc;
            end else begin
                j_next = j_inc;
            end
        end
        if (cmd.merge_cap) begin
            if (side_reg) begin
                head_l_next = rdata;
            end else begin
                head_r_next = rdata;
            end
        end
        if (cmd.span_next) begin
            lo_next = hi_reg;
        end
        if (cmd.pass_next) begin
            w_next    = {w_reg[WW-2:0], 1'b0};
            lo_next   = '0;
            bank_next = !bank_reg;
        end
        if (cmd.out_init) begin
            k_next = '0;
        end
        if (cmd.out_load) begin
            out_valid_next             = 1'b1;
            out_data_next.sorted_value = rdata;
            out_data_next.last_out     = (k_inc == count_reg);
            out_data_next.overflow     = ovf_reg;
            k_next                     = k_inc;
            // run finished: ready for the next one
            if (k_inc == count_reg) begin
                count_next = '0;
                ovf_next   = 1'b0;
                bank_next  = 1'b0;
            end
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            bank_reg      <= 1'b0;
            w_reg         <= W_ONE;
            lo_reg        <= '0;
            mid_reg       <= '0;
            hi_reg        <= '0;
            i_reg         <= '0;
            j_reg         <= '0;
            k_reg         <= '0;
            side_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            count_reg     <= count_next;
            ovf_reg       <= ovf_next;
            bank_reg      <= bank_next;
            w_reg         <= w_next;
            lo_reg        <= lo_next;
            mid_reg       <= mid_next;
            hi_reg        <= hi_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            k_reg         <= k_next;
            side_reg      <= side_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        head_l_reg   <= head_l_next;
        head_r_reg   <= head_r_next;
        out_data_reg <= out_data_next;
    end

    // Status and outputs
    assign status.in_last   = s_data.last;
    assign status.w_lt_n    = w_reg < WW'(count_reg);
    assign status.span_done = k_reg == hi_reg;
    assign status.span_last = hi_reg == count_reg;
    assign status.out_free  = !out_valid_reg || m_ready;
    assign status.out_last  = k_inc == count_reg;

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

endmodule
